// ===== rtl/wfra_pkg.sv =====
// Package for the windowed frame rate average block: widths, slot record,
// register indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wfra_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);

	localparam int IN_W       = 24;
	localparam int RATE_W     = 25;
	localparam int STAMP_W    = 48;
	localparam int WIN_W      = 24;
	localparam int FS_W       = 16;
	localparam int DIAL_W     = 16;
	localparam int SUM_W      = RATE_W + CNT_W;

	localparam int DIV_NUM_W  = RATE_W + 8;
	localparam int DIV_DEN_W  = 24;
	localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;

	localparam logic [WIN_W-1:0]     WINDOW_RST   = 24'd1000000;
	localparam logic [FS_W-1:0]      SCALE_RST    = 16'd100;
	localparam logic [IN_W-1:0]      MIN_INTERVAL = 24'd10;
	localparam logic [DIV_NUM_W-1:0] RATE_NUM     = 33'd256000000;
	localparam logic [RATE_W-1:0]    RATE_MAX     = 25'd25600000;

	typedef struct packed {
		logic               valid;
		logic [STAMP_W-1:0] stamp;
		logic [RATE_W-1:0]  rate;
	} slot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RATE_WAIT,
		ST_STORE,
		ST_MEAN,
		ST_DIAL,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/wfra_if.sv =====
// Channel interfaces of the windowed frame rate average block: input,
// result and configuration write. Depends on wfra_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wfra_in_if;
	logic                      valid;
	logic                      ready;
	logic [wfra_pkg::IN_W-1:0] frame_interval_us;

	modport source (output valid, output frame_interval_us, input ready);
	modport sink   (input valid, input frame_interval_us, output ready);
endinterface

interface wfra_out_if;
	logic                        valid;
	logic                        ready;
	logic [wfra_pkg::RATE_W-1:0] mean_rate_q8;
	logic [wfra_pkg::DIAL_W-1:0] dial_turns_q16;

	modport source (output valid, output mean_rate_q8, output dial_turns_q16, input ready);
	modport sink   (input valid, input mean_rate_q8, input dial_turns_q16, output ready);
endinterface

interface wfra_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wfra_pkg::CFG_IDX_W-1:0]  index;
	logic [wfra_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/wfra_cell.sv =====
// One slot of the sample ring: valid flag, time stamp and rate, taken from
// the neighbor on each shift. Depends on wfra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfra_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            shift,
	input  wire wfra_pkg::slot_t nbr,
	output wfra_pkg::slot_t      cur
);

	logic                         valid_q;
	logic [wfra_pkg::STAMP_W-1:0] stamp_q;
	logic [wfra_pkg::RATE_W-1:0]  rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nbr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			stamp_q <= nbr.stamp;
			rate_q  <= nbr.rate;
		end
	end

	assign cur = {valid_q, stamp_q, rate_q};

endmodule

`default_nettype wire

// ===== rtl/wfra_div.sv =====
// Shared restoring divider, one quotient bit per cycle; quotient holds
// until the next start. Depends on wfra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wfra_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [wfra_pkg::DIV_NUM_W-1:0] num,
	input  wire logic [wfra_pkg::DIV_DEN_W-1:0] den,
	output logic                                busy,
	output logic [wfra_pkg::DIV_NUM_W-1:0]      quot
);

	localparam int NW = wfra_pkg::DIV_NUM_W;
	localparam int DW = wfra_pkg::DIV_DEN_W;

	logic                              busy_q;
	logic [wfra_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [NW-1:0]                     work_q;
	logic [DW-1:0]                     rem_q;
	logic [DW-1:0]                     den_q;
	logic [DW:0]                       trial;
	logic [DW:0]                       diff;
	logic                              ge;

	assign trial = {rem_q, work_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= wfra_pkg::DIV_CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == wfra_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			work_q <= {work_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = work_q;

endmodule

`default_nettype wire

// ===== rtl/windowed_frame_rate_average.sv =====
// Windowed frame rate average: one result (mean rate, dial angle) per frame
// interval of 10 us or more; shorter intervals are taken and dropped. A
// counted interval runs a serial divide for the rate overlapping a walk of
// the slot ring, a second ring walk to store and sum, and serial divides for
// the mean and the dial angle. The divides are serial as the divider is
// shared, and the ring is walked one slot per cycle. The next interval
// is taken while a result still waits at the output. Depends on wfra_pkg,
// wfra_if, wfra_cell and wfra_div.
`timescale 1ns / 1ps
`default_nettype none

module windowed_frame_rate_average (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wfra_in_if.sink    in_ch,
	wfra_out_if.source out_ch,
	wfra_cfg_if.sink   cfg
);

	localparam int SLOTS = wfra_pkg::SLOTS;
	localparam int IW    = wfra_pkg::SLOT_IW;
	localparam int CW    = wfra_pkg::CNT_W;
	localparam int SW    = wfra_pkg::SUM_W;
	localparam int NW    = wfra_pkg::DIV_NUM_W;
	localparam int DW    = wfra_pkg::DIV_DEN_W;
	localparam int RW    = wfra_pkg::RATE_W;

	wfra_pkg::state_t state_q, state_d;

	logic [wfra_pkg::WIN_W-1:0]   window_q;
	logic [wfra_pkg::FS_W-1:0]    scale_q;
	logic [wfra_pkg::STAMP_W-1:0] elapsed_q;
	logic [CW-1:0]                step_q;
	logic                         free_found_q;
	logic [IW-1:0]                free_idx_q;
	logic [IW-1:0]                oldest_idx_q;
	logic [wfra_pkg::WIN_W-1:0]   oldest_age_q;
	logic [IW-1:0]                target_q;
	logic [RW-1:0]                rate_q;
	logic [SW-1:0]                sum_q;
	logic [CW-1:0]                cnt_q;
	logic [RW-1:0]                mean_q;
	logic [wfra_pkg::DIAL_W-1:0]  dial_q;
	logic                         out_valid_q;
	logic [RW-1:0]                out_mean_q;
	logic [wfra_pkg::DIAL_W-1:0]  out_dial_q;

	wfra_pkg::slot_t slot_cur [SLOTS];
	wfra_pkg::slot_t slot_nxt [SLOTS];
	wfra_pkg::slot_t head;
	wfra_pkg::slot_t wb;
	logic [SLOTS-1:0] valid_vec;

	logic                         shift;
	logic                         item_go;
	logic                         last;
	logic [IW-1:0]                step_idx;
	logic [wfra_pkg::STAMP_W-1:0] age;
	logic                         expire;
	logic                         still_valid;
	logic [SW-1:0]                sum_d;
	logic [CW-1:0]                cnt_d;
	logic [wfra_pkg::FS_W-1:0]    scale_eff;
	logic                         out_load;

	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic          div_busy;
	logic [NW-1:0] div_quot;

	// slot ring, head at slot 0, tail fed by the head update
	for (genvar i = 0; i < SLOTS; i++) begin : g_slot
		if (i == SLOTS - 1) begin : g_tail
			assign slot_nxt[i] = wb;
		end else begin : g_mid
			assign slot_nxt[i] = slot_cur[i+1];
		end
		assign valid_vec[i] = slot_cur[i].valid;
		wfra_cell u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nbr    (slot_nxt[i]),
			.cur    (slot_cur[i])
		);
	end

	wfra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	assign head        = slot_cur[0];
	assign step_idx    = step_q[IW-1:0];
	assign last        = (step_q == CW'(SLOTS - 1));
	assign age         = elapsed_q - head.stamp;
	assign expire      = head.valid && (age > {24'b0, window_q});
	assign still_valid = head.valid && !expire;
	assign scale_eff   = (scale_q == '0) ? wfra_pkg::FS_W'(1) : scale_q;

	assign in_ch.ready = (state_q == wfra_pkg::ST_IDLE);
	assign item_go     = in_ch.valid && in_ch.ready
		&& (in_ch.frame_interval_us >= wfra_pkg::MIN_INTERVAL);
	assign cfg.ready   = 1'b1;

	always_comb begin
		wb = head;
		if (state_q == wfra_pkg::ST_SCAN && expire) begin
			wb.valid = 1'b0;
		end
		if (state_q == wfra_pkg::ST_STORE && step_idx == target_q) begin
			wb.valid = 1'b1;
			wb.stamp = elapsed_q;
			wb.rate  = rate_q;
		end
	end

	assign sum_d = wb.valid ? (sum_q + SW'(wb.rate)) : sum_q;
	assign cnt_d = wb.valid ? (cnt_q + 1'b1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		shift     = 1'b0;
		div_start = 1'b0;
		div_num   = wfra_pkg::RATE_NUM;
		div_den   = in_ch.frame_interval_us;
		out_load  = 1'b0;
		case (state_q)
			wfra_pkg::ST_IDLE: begin
				if (item_go) begin
					div_start = 1'b1;
					state_d   = wfra_pkg::ST_SCAN;
				end
			end
			wfra_pkg::ST_SCAN: begin
				shift = 1'b1;
				if (last) begin
					state_d = wfra_pkg::ST_RATE_WAIT;
				end
			end
			wfra_pkg::ST_RATE_WAIT: begin
				if (!div_busy) begin
					state_d = wfra_pkg::ST_STORE;
				end
			end
			wfra_pkg::ST_STORE: begin
				shift   = 1'b1;
				div_num = NW'(sum_d);
				div_den = DW'(cnt_d);
				if (last) begin
					div_start = 1'b1;
					state_d   = wfra_pkg::ST_MEAN;
				end
			end
			wfra_pkg::ST_MEAN: begin
				div_num = {div_quot[RW-1:0], 8'b0};
				div_den = DW'(scale_eff);
				if (!div_busy) begin
					div_start = 1'b1;
					state_d   = wfra_pkg::ST_DIAL;
				end
			end
			wfra_pkg::ST_DIAL: begin
				if (!div_busy) begin
					state_d = wfra_pkg::ST_OUT;
				end
			end
			wfra_pkg::ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = wfra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wfra_pkg::ST_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= wfra_pkg::WINDOW_RST;
			scale_q      <= wfra_pkg::SCALE_RST;
			elapsed_q    <= '0;
			step_q       <= '0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					wfra_pkg::CFG_WINDOW: window_q <= cfg.data[wfra_pkg::WIN_W-1:0];
					wfra_pkg::CFG_SCALE:  scale_q  <= cfg.data[wfra_pkg::FS_W-1:0];
					default: ;
				endcase
			end
			if (item_go) begin
				elapsed_q <= elapsed_q + wfra_pkg::STAMP_W'(in_ch.frame_interval_us);
			end
			if (shift) begin
				step_q <= last ? '0 : step_q + 1'b1;
			end
			if (item_go) begin
				free_found_q <= 1'b0;
			end else if (state_q == wfra_pkg::ST_SCAN && !still_valid) begin
				free_found_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-transaction working values
	always_ff @(posedge clk) begin
		if (item_go) begin
			oldest_idx_q <= '0;
			oldest_age_q <= '0;
		end
		if (state_q == wfra_pkg::ST_SCAN) begin
			if (!still_valid && !free_found_q) begin
				free_idx_q <= step_idx;
			end
			if (still_valid && age[wfra_pkg::WIN_W-1:0] > oldest_age_q) begin
				oldest_age_q <= age[wfra_pkg::WIN_W-1:0];
				oldest_idx_q <= step_idx;
			end
		end
		if (state_q == wfra_pkg::ST_RATE_WAIT && !div_busy) begin
			target_q <= free_found_q ? free_idx_q : oldest_idx_q;
			rate_q   <= div_quot[RW-1:0];
			sum_q    <= '0;
			cnt_q    <= '0;
		end
		if (state_q == wfra_pkg::ST_STORE) begin
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
		if (state_q == wfra_pkg::ST_MEAN && !div_busy) begin
			mean_q <= div_quot[RW-1:0];
		end
		if (state_q == wfra_pkg::ST_DIAL && !div_busy) begin
			dial_q <= div_quot[wfra_pkg::DIAL_W-1:0];
		end
		if (out_load) begin
			out_mean_q <= mean_q;
			out_dial_q <= dial_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.mean_rate_q8   = out_mean_q;
	assign out_ch.dial_turns_q16 = out_dial_q;

	a_store_leaves_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfra_pkg::ST_STORE && last) |=> (valid_vec != '0))
		else $error("no valid slot after store pass");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mean_q <= wfra_pkg::RATE_MAX))
		else $error("mean rate above the largest sample rate");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= CW'(SLOTS - 1))
		else $error("ring step counter out of range");

endmodule

`default_nettype wire
